// ===== rtl/gng_pkg.sv =====
// shared types, constants and helper functions of the gaussian noise generator
package gng_pkg;

  localparam logic [63:0] SEED_RESET  = 64'd12345;
  localparam logic [4:0]  REDRAW_MAX  = 5'd16;
  localparam int          QDEPTH      = 2;
  localparam int          QAW         = 1;
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [1:0]  IDX_MODE = 2'd0;
  localparam logic [1:0]  IDX_MEAN = 2'd1;
  localparam logic [1:0]  IDX_STD  = 2'd2;
  localparam logic        OP_DRAW  = 1'b0;
  localparam logic        OP_LOAD  = 1'b1;

  typedef struct packed {
    logic        gauss;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [63:0] st;
  } gng_word_t;

  typedef enum logic [1:0] {F_IDLE, F_W2, F_REDRAW, F_PUSH} gng_fstate_t;

  typedef enum logic [2:0] {
    B_IDLE, B_UNI, B_LOG, B_RMUL, B_SQRT, B_GMUL, B_SMUL, B_OUT
  } gng_bstate_t;

  function automatic logic [63:0] advance(input logic [63:0] s);
    logic [63:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

  // base-2 log, integer part from leading one, 26 fraction bits by squaring
  function automatic logic [30:0] log2_q26(input logic [31:0] v);
    logic [4:0]  e;
    logic [63:0] m;
    logic [63:0] sq;
    logic [25:0] frac;
    e = '0;
    frac = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) e = 5'(i);
    end
    m = 64'(v) << (5'd31 - e);
    for (int k = 0; k < 26; k++) begin
      sq = m * m;
      m = sq >> 31;
      frac = {frac[24:0], m[32]};
      if (m[32]) m = m >> 1;
    end
    return {e, frac};
  endfunction

  function automatic logic signed [33:0] arc_q(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return $signed({2'b00, a});
  endfunction

endpackage

// ===== rtl/gng_front.sv =====
// front end: takes words, reseeds, steps the xorshift state and collects draws
module gng_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_operation,
  input  logic [63:0]        in_seed_value,
  input  logic               draw_mode,
  input  logic               q_full,
  output logic               q_push,
  output gng_pkg::gng_word_t q_word
);

  gng_pkg::gng_fstate_t state_r, state_nxt;
  logic [63:0] st_r, st_nxt;
  logic [31:0] w1_r, w1_nxt, w2_r, w2_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        gauss_r, gauss_nxt;
  logic [63:0] adv;
  logic        take;

  assign adv  = gng_pkg::advance(st_r);
  assign take = push && !full;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gng_pkg::F_IDLE: begin
        if (take && in_operation == gng_pkg::OP_DRAW)
          state_nxt = draw_mode ? gng_pkg::F_W2 : gng_pkg::F_PUSH;
      end
      gng_pkg::F_W2: state_nxt = gng_pkg::F_REDRAW;
      gng_pkg::F_REDRAW: begin
        if (!(w1_r == '0 && cnt_r != gng_pkg::REDRAW_MAX)) state_nxt = gng_pkg::F_PUSH;
      end
      gng_pkg::F_PUSH: begin
        if (!q_full) state_nxt = gng_pkg::F_IDLE;
      end
      default: state_nxt = gng_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    full      = (state_r != gng_pkg::F_IDLE);
    st_nxt    = st_r;
    w1_nxt    = w1_r;
    w2_nxt    = w2_r;
    cnt_nxt   = cnt_r;
    gauss_nxt = gauss_r;
    q_push    = 1'b0;
    unique case (state_r)
      gng_pkg::F_IDLE: begin
        if (take) begin
          if (in_operation == gng_pkg::OP_LOAD) begin
            st_nxt = in_seed_value;
          end else begin
            st_nxt    = adv;
            w1_nxt    = adv[31:0];
            gauss_nxt = draw_mode;
          end
        end
      end
      gng_pkg::F_W2: begin
        st_nxt  = adv;
        w2_nxt  = adv[31:0];
        cnt_nxt = '0;
      end
      gng_pkg::F_REDRAW: begin
        // redraw u1 while zero, bounded
        if (w1_r == '0 && cnt_r != gng_pkg::REDRAW_MAX) begin
          st_nxt  = adv;
          w1_nxt  = adv[31:0];
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      gng_pkg::F_PUSH: q_push = !q_full;
      default: ;
    endcase
    q_word.gauss = gauss_r;
    q_word.w1    = (gauss_r && w1_r == '0) ? 32'd1 : w1_r;
    q_word.w2    = w2_r;
    q_word.st    = st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gng_pkg::F_IDLE;
      st_r    <= gng_pkg::SEED_RESET;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
    w1_r    <= w1_nxt;
    w2_r    <= w2_nxt;
    cnt_r   <= cnt_nxt;
    gauss_r <= gauss_nxt;
  end

endmodule

// ===== rtl/gng_fifo.sv =====
// short queue of draw words between front and back
module gng_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr,
  input  gng_pkg::gng_word_t wdata,
  output logic               q_full,
  input  logic               rd,
  output gng_pkg::gng_word_t rdata,
  output logic               q_empty
);

  gng_pkg::gng_word_t mem_r [gng_pkg::QDEPTH];
  logic [gng_pkg::QAW-1:0] wp_r, rp_r;
  logic [gng_pkg::QAW:0]   cnt_r;

  assign q_full  = (cnt_r == (gng_pkg::QAW+1)'(gng_pkg::QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (gng_pkg::QAW+1)'(wr) - (gng_pkg::QAW+1)'(rd);
    end
  end

endmodule

// ===== rtl/gng_back.sv =====
// back end: log, square root, cordic cosine and scaling, holds the result word
module gng_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  gng_pkg::gng_word_t q_word,
  output logic               q_pop,
  input  logic [31:0]        mean_value,
  input  logic [30:0]        std_value,
  input  logic               pop,
  output logic               empty,
  output logic [31:0]        out_sample,
  output logic [63:0]        out_state_after
);

  localparam logic [30:0] LOG_MAX = gng_pkg::log2_q26(32'hFFFFFFFF);

  gng_pkg::gng_bstate_t state_r, state_nxt;
  logic                 gauss_r;
  logic [31:0]          w1_r;
  logic [63:0]          st_r;
  logic [4:0]           e_r;
  logic [31:0]          m_r;
  logic [25:0]          frac_r;
  logic [4:0]           k_r;
  logic [32:0]          r_r;
  logic [63:0]          sv_r, sres_r, sbit_r;
  logic signed [33:0]   x_r, y_r, z_r;
  logic [1:0]           quad_r;
  logic [4:0]           cc_r;
  logic                 cact_r;
  logic signed [31:0]   g_r;
  logic signed [39:0]   scaled_r;
  logic                 res_valid_r;
  logic [31:0]          res_sample_r;
  logic [63:0]          res_state_r;

  logic                 res_free, start, write_res;
  logic [4:0]           e0;
  logic [31:0]          phase, shifted;
  logic [63:0]          sq;
  logic [32:0]          t;
  logic [30:0]          lx, d;
  logic [61:0]          rp;
  logic [63:0]          sroot;
  logic signed [33:0]   dx, dy, c;
  logic signed [64:0]   gp;
  logic signed [63:0]   sp;
  logic signed [40:0]   sum;
  logic [31:0]          sat;
  logic [56:0]          ux;
  logic [32:0]          ur;
  logic [24:0]          uq;

  assign res_free  = !res_valid_r || pop;
  assign start     = (state_r == gng_pkg::B_IDLE) && !q_empty;
  assign q_pop     = start;
  assign write_res = (state_r == gng_pkg::B_OUT) && res_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gng_pkg::B_IDLE: if (start) state_nxt = q_word.gauss ? gng_pkg::B_LOG : gng_pkg::B_UNI;
      gng_pkg::B_UNI:  state_nxt = gng_pkg::B_OUT;
      gng_pkg::B_LOG:  if (k_r == 5'd25) state_nxt = gng_pkg::B_RMUL;
      gng_pkg::B_RMUL: state_nxt = gng_pkg::B_SQRT;
      gng_pkg::B_SQRT: if (sbit_r == 64'd1) state_nxt = gng_pkg::B_GMUL;
      gng_pkg::B_GMUL: state_nxt = gng_pkg::B_SMUL;
      gng_pkg::B_SMUL: state_nxt = gng_pkg::B_OUT;
      gng_pkg::B_OUT:  if (res_free) state_nxt = gng_pkg::B_IDLE;
      default:         state_nxt = gng_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    e0 = '0;
    for (int i = 0; i < 32; i++) begin
      if (q_word.w1[i]) e0 = 5'(i);
    end
    phase   = q_word.w2 + {31'd0, q_word.w2[31]};
    shifted = phase + 32'h20000000;
    sq      = {32'd0, m_r} * {32'd0, m_r};
    t       = sq[63:31];
    lx      = {e_r, frac_r};
    d       = (LOG_MAX > lx) ? LOG_MAX - lx : '0;
    rp      = {31'd0, d} * {31'd0, gng_pkg::TWO_LN2_Q30};
    sroot   = sres_r + sbit_r;
    dx      = y_r >>> cc_r;
    dy      = x_r >>> cc_r;
    case (quad_r)
      2'd0:    c = x_r;
      2'd1:    c = -y_r;
      2'd2:    c = -x_r;
      default: c = y_r;
    endcase
    gp  = $signed({1'b0, sres_r[29:0]}) * c;
    sp  = $signed({1'b0, std_value}) * g_r;
    sum = 41'(signed'(mean_value)) + 41'(scaled_r);
    if (sum > 41'sd2147483647)       sat = 32'h7FFFFFFF;
    else if (sum < -41'sd2147483648) sat = 32'h80000000;
    else                             sat = sum[31:0];
    // divide by 2^32-1: fold the high part back in, one correction
    ux = {1'b0, w1_r, 24'd0} + 57'h7FFFFFFF;
    ur = {1'b0, ux[31:0]} + {8'd0, ux[56:32]};
    uq = (ur >= 33'hFFFFFFFF) ? ux[56:32] + 25'd1 : ux[56:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gng_pkg::B_IDLE;
      res_valid_r <= 1'b0;
      cact_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (write_res)  res_valid_r <= 1'b1;
      else if (pop)   res_valid_r <= 1'b0;
      if (start && q_word.gauss)  cact_r <= 1'b1;
      else if (cc_r == 5'd31)     cact_r <= 1'b0;
    end

    if (start) begin
      gauss_r <= q_word.gauss;
      w1_r    <= q_word.w1;
      st_r    <= q_word.st;
      e_r     <= e0;
      m_r     <= q_word.w1 << (5'd31 - e0);
      frac_r  <= '0;
      k_r     <= '0;
      x_r     <= gng_pkg::CORDIC_X0;
      y_r     <= '0;
      z_r     <= $signed({4'd0, shifted[29:0]}) - 34'sd536870912;
      quad_r  <= shifted[31:30];
      cc_r    <= '0;
    end else begin
      if (cact_r) begin
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - gng_pkg::arc_q(cc_r);
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + gng_pkg::arc_q(cc_r);
        end
        cc_r <= cc_r + 5'd1;
      end
      if (state_r == gng_pkg::B_LOG) begin
        frac_r <= {frac_r[24:0], t[32]};
        m_r    <= t[32] ? t[32:1] : t[31:0];
        k_r    <= k_r + 5'd1;
      end
    end

    if (state_r == gng_pkg::B_UNI) scaled_r <= 40'({15'd0, uq});
    if (state_r == gng_pkg::B_RMUL) begin
      r_r    <= 33'((rp + 62'd536870912) >> 30);
      sv_r   <= '0;
      sres_r <= '0;
      sbit_r <= 64'd1 << 62;
    end
    if (state_r == gng_pkg::B_LOG && k_r == 5'd25) ;
    if (state_r == gng_pkg::B_SQRT) begin
      if (sbit_r == (64'd1 << 62)) begin
        // first step works on the loaded operand
        if ({5'd0, r_r, 26'd0} >= sroot) begin
          sv_r   <= {5'd0, r_r, 26'd0} - sroot;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sv_r   <= {5'd0, r_r, 26'd0};
          sres_r <= sres_r >> 1;
        end
      end else if (sv_r >= sroot) begin
        sv_r   <= sv_r - sroot;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
    if (state_r == gng_pkg::B_GMUL) g_r <= 32'((gp + 65'sd2147483648) >>> 32);
    if (state_r == gng_pkg::B_SMUL) scaled_r <= 40'((sp + 64'sd8388608) >>> 24);
    if (write_res) begin
      res_sample_r <= gauss_r ? sat : scaled_r[31:0];
      res_state_r  <= st_r;
    end
  end

  assign empty           = !res_valid_r;
  assign out_sample      = res_sample_r;
  assign out_state_after = res_state_r;

endmodule

// ===== rtl/gaussian_noise_generator.sv =====
// top level: uniform and gaussian sample source with apb register port
// a load word gives no result; a uniform draw gives one result word, and a gaussian draw passes
// the front (bounded u1 redraws) and then the back (26-step log, radius multiply, 32-step
// square root, then the gaussian and scale multiplies; cordic runs alongside)
// front and back overlap through a 2-word queue, so the front takes draws while the back is busy
// reset: generator state 12345, mode gaussian, mean 0, std 1.0, all queues empty
module gaussian_noise_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_operation,
  input  logic [63:0] in_seed_value,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] out_sample,
  output logic [63:0] out_state_after,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        mode_r;
  logic [31:0] mean_r;
  logic [30:0] std_r;
  logic        wr_en;

  logic               q_full, q_push, q_empty, q_pop;
  gng_pkg::gng_word_t q_wdata, q_rdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      mean_r <= '0;
      std_r  <= 31'd16777216;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        gng_pkg::IDX_MODE: mode_r <= pwdata[0];
        gng_pkg::IDX_MEAN: mean_r <= pwdata;
        gng_pkg::IDX_STD:  std_r  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      gng_pkg::IDX_MODE: prdata = {31'd0, mode_r};
      gng_pkg::IDX_MEAN: prdata = mean_r;
      gng_pkg::IDX_STD:  prdata = {1'b0, std_r};
      default:           prdata = '0;
    endcase
  end

  gng_front u_front (
    .clk, .rst_n, .push, .full, .in_operation, .in_seed_value,
    .draw_mode (mode_r),
    .q_full, .q_push,
    .q_word    (q_wdata)
  );

  gng_fifo u_fifo (
    .clk, .rst_n,
    .wr    (q_push),
    .wdata (q_wdata),
    .q_full,
    .rd    (q_pop),
    .rdata (q_rdata),
    .q_empty
  );

  gng_back u_back (
    .clk, .rst_n, .q_empty,
    .q_word     (q_rdata),
    .q_pop,
    .mean_value (mean_r),
    .std_value  (std_r),
    .pop, .empty, .out_sample, .out_state_after
  );

endmodule

// ===== bench/gng_checker.sv =====
// checker for the noise generator: predicts every result word and compares it
`timescale 1ns / 100ps
module gng_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic        in_operation,
  input  logic [63:0] in_seed_value,
  input  logic        pop,
  input  logic        empty,
  input  logic [31:0] out_sample,
  input  logic [63:0] out_state_after,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);

  typedef struct {
    logic [31:0] sample;
    logic [63:0] state;
  } noise_word_t;

  localparam longint ROT_X0 = 64'sd652032874;
  localparam longint LN2_X2 = 64'sd1488522236;
  localparam longint ANGLE_STEP [32] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
    'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
    'h00000001, 'h00000000
  };

  logic [63:0]  rng_state;
  logic         gauss_mode;
  logic [31:0]  mean_reg;
  logic [30:0]  std_reg;
  noise_word_t  sample_queue[$];

  assign pending = sample_queue.size();

  function automatic logic [31:0] step_rng(ref logic [63:0] st);
    logic [63:0] x;
    x = st;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    st = x;
    return x[31:0];
  endfunction

  function automatic longint unsigned lg_q26(input logic [31:0] v);
    int unsigned exp2;
    longint unsigned mant, frac;
    exp2 = 0;
    frac = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) exp2 = i;
    end
    mant = longint'(v) << (31 - exp2);
    for (int k = 0; k < 26; k++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        frac = frac | 1;
        mant = mant >> 1;
      end
    end
    return (longint'(exp2) << 26) | frac;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, bitpos;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v = v - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  // quadrant removed, residual angle through the rotation
  function automatic longint cos_q30(input logic [31:0] phase);
    logic [31:0] shifted;
    logic [1:0]  quad;
    longint x, y, z, dx, dy;
    shifted = phase + 32'h2000_0000;
    quad = shifted[31:30];
    z = longint'({34'd0, shifted[29:0]}) - 64'sh2000_0000;
    x = ROT_X0;
    y = 0;
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ANGLE_STEP[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ANGLE_STEP[i];
      end
    end
    case (quad)
      2'd0: return x;
      2'd1: return -y;
      2'd2: return -x;
      default: return y;
    endcase
  endfunction

  function automatic logic [31:0] gauss_draw(ref logic [63:0] st);
    logic [31:0] w1, w2;
    int tries;
    longint unsigned lmax, lw, d, r, s;
    longint c, g, scaled, sum;
    w1 = step_rng(st);
    w2 = step_rng(st);
    tries = 0;
    while (w1 == 0 && tries < gng_pkg::REDRAW_MAX) begin
      w1 = step_rng(st);
      tries++;
    end
    if (w1 == 0) w1 = 32'd1;
    lmax = lg_q26(32'hFFFF_FFFF);
    lw = lg_q26(w1);
    d = (lmax > lw) ? lmax - lw : 0;
    r = (d * LN2_X2 + (64'd1 << 29)) >> 30;
    s = int_sqrt(r << 26);
    c = cos_q30(w2 + {31'd0, w2[31]});
    g = (longint'(s) * c + (64'sd1 <<< 31)) >>> 32;
    scaled = (longint'({33'd0, std_reg}) * g + (64'sd1 <<< 23)) >>> 24;
    sum = longint'($signed(mean_reg)) + scaled;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  function automatic noise_word_t predict_draw();
    noise_word_t wd;
    logic [31:0] w;
    longint unsigned q;
    if (!gauss_mode) begin
      w = step_rng(rng_state);
      q = ((longint'(w) << 24) + 64'h7FFF_FFFF) / 64'hFFFF_FFFF;
      wd.sample = q[31:0];
    end else begin
      wd.sample = gauss_draw(rng_state);
    end
    wd.state = rng_state;
    return wd;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    noise_word_t head;
    if (!rst_n) begin
      rng_state = gng_pkg::SEED_RESET;
      gauss_mode = 1'b1;
      mean_reg = '0;
      std_reg = 31'd16777216;
      sample_queue.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          gng_pkg::IDX_MODE: gauss_mode = pwdata[0];
          gng_pkg::IDX_MEAN: mean_reg = pwdata;
          gng_pkg::IDX_STD:  std_reg = pwdata[30:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (sample_queue.size() == 0) begin
          report_mismatch("unexpected word", 64'd0, {32'd0, out_sample});
        end else begin
          head = sample_queue.pop_front();
          if (out_sample !== head.sample)
            report_mismatch("sample", {32'd0, head.sample}, {32'd0, out_sample});
          if (out_state_after !== head.state)
            report_mismatch("state_after", head.state, out_state_after);
        end
      end
      if (push && !full) begin
        if (in_operation == gng_pkg::OP_LOAD) rng_state = in_seed_value;
        else sample_queue.push_back(predict_draw());
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// top of the noise generator bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module testbench;

  localparam int STALL_LIMIT = 6000;
  localparam int SETTLE      = 150;
  localparam int HOLD_LEN    = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_operation = gng_pkg::OP_DRAW;
  logic [63:0] in_seed_value = '0;
  logic        pop = 1'b0;
  logic        empty;
  logic [31:0] out_sample;
  logic [63:0] out_state_after;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches, pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_cycles = 0;
  int stall_count = 0;
  int draws_sent = 0;
  int loads_sent = 0;
  int cfg_writes = 0;

  always #1 clk = ~clk;

  gaussian_noise_generator dut (.*);

  gng_checker checker_i (.*);

  // receiver with random gaps and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_req != hold_ack) begin
      pop <= 1'b0;
      hold_ack = hold_req;
      hold_cycles = HOLD_LEN;
    end else if (hold_cycles > 0) begin
      pop <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel || !rst_n) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without progress", stall_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic op, input logic [63:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_operation <= op;
    in_seed_value <= seed;
    @(posedge clk);
    while (full) @(posedge clk);
    if (op == gng_pkg::OP_LOAD) loads_sent++;
    else draws_sent++;
  endtask

  // a load gives no word, so let the block settle after the last one
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [63:0] rand_seed();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return '1;
      2: return 64'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick_mean();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_std();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h7FFF_FFFF;
      2: return 32'd16777216;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, zero seed, all-ones seed, saturation both ways
    send_idle_pct = 11;
    recv_idle_pct = 66;
    repeat (3) send_word(gng_pkg::OP_DRAW, '0);
    send_word(gng_pkg::OP_LOAD, 64'd0);
    send_word(gng_pkg::OP_DRAW, '1);
    drain();
    cfg_write(gng_pkg::IDX_MODE, 32'd0);
    send_word(gng_pkg::OP_DRAW, '0);
    send_word(gng_pkg::OP_LOAD, '1);
    repeat (2) send_word(gng_pkg::OP_DRAW, '0);
    send_word(gng_pkg::OP_LOAD, 64'd1);
    send_word(gng_pkg::OP_DRAW, '0);
    drain();
    cfg_write(gng_pkg::IDX_MODE, 32'hFFFF_FFFF);
    cfg_write(gng_pkg::IDX_MEAN, 32'h7FFF_FFFF);
    cfg_write(gng_pkg::IDX_STD, 32'h7FFF_FFFF);
    repeat (3) send_word(gng_pkg::OP_DRAW, '0);
    drain();
    cfg_write(gng_pkg::IDX_MEAN, 32'h8000_0000);
    repeat (3) send_word(gng_pkg::OP_DRAW, '0);
    drain();
    cfg_write(gng_pkg::IDX_STD, 32'd0);
    cfg_write(gng_pkg::IDX_MEAN, $urandom);
    send_word(gng_pkg::OP_DRAW, '0);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      send_idle_pct = (phase < 3) ? 11 : (phase < 6) ? 66 : 0;
      recv_idle_pct = (phase < 3) ? 66 : (phase < 6) ? 11 : 0;
      drain();
      cfg_write(gng_pkg::IDX_MODE, ($urandom_range(9) < 7) ? 32'd1 : 32'd0);
      cfg_write(gng_pkg::IDX_MEAN, pick_mean());
      cfg_write(gng_pkg::IDX_STD, pick_std());
      if (phase == 6) hold_req = hold_req + 1;
      for (int n = 0; n < 55; n++) begin
        if ($urandom_range(9) == 0) send_word(gng_pkg::OP_LOAD, rand_seed());
        else send_word(gng_pkg::OP_DRAW, {$urandom, $urandom});
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d draws and %0d seed loads over %0d register writes",
             draws_sent, loads_sent, cfg_writes);
    $display("uniform and gaussian modes, zero seed, saturation, stalls on both sides");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
